>>> sv/lhc_pkg.sv
// Package for the location history compactor: character codes, sizes and shared types.
package lhc_pkg;

   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ONE   = 8'h31;

   localparam logic [2:0] LOCATION_LAST = 3'd5;
   localparam logic [1:0] CODE_MINUS    = 2'd0;
   localparam logic [1:0] CODE_ZERO     = 2'd1;
   localparam logic [1:0] CODE_PLUS     = 2'd2;

   localparam int QUEUE_DEPTH = 4;

   // results of one character: count 0..2 and the characters in order
   typedef struct packed {
      logic [1:0] cnt;
      logic [7:0] ch0;
      logic [7:0] ch1;
   } lhc_res_type;

   typedef struct packed {
      logic       last;
      logic [7:0] ch;
   } lhc_entry_type;

   // token as diff+1
   function automatic logic [1:0] token_code(input logic [7:0] first, input logic [7:0] second);
      logic [1:0] code;
      code = CODE_ZERO;
      if (second == CH_ONE && first == CH_PLUS) begin
         code = CODE_PLUS;
      end else if (second == CH_ONE && first == CH_MINUS) begin
         code = CODE_MINUS;
      end
      return code;
   endfunction

   // pair character: '!' + 9*first record weight + second record weight
   function automatic logic [7:0] pair_char(input logic [3:0] w_first, input logic [3:0] w_second);
      logic [7:0] nine_w;
      nine_w = {w_first, 3'b000} + {4'b0000, w_first};
      return CH_BANG + nine_w + {4'b0000, w_second};
   endfunction

endpackage

>>> sv/lhc_step.sv
// Per-character parse state and result generation for the compactor.
module lhc_step (
   input  logic                clock,
   input  logic                reset,
   input  logic                stage_valid,
   input  logic                stage_advance,
   input  logic [7:0]          stage_char,
   input  logic                stage_end,
   output lhc_pkg::lhc_res_type res
);

   logic       in_location_ff, in_location_in;
   logic [2:0] char_position_ff, char_position_in;
   logic [7:0] token_first_ff, token_first_in;
   logic [1:0] lat_code_ff, lat_code_in;
   logic       pending_valid_ff, pending_valid_in;
   logic [3:0] pending_weight_ff, pending_weight_in;

   always_comb begin
      logic [1:0] lon_code;
      logic [3:0] rec;
      lhc_pkg::lhc_res_type r;

      in_location_in    = in_location_ff;
      char_position_in  = char_position_ff;
      token_first_in    = token_first_ff;
      lat_code_in       = lat_code_ff;
      pending_valid_in  = pending_valid_ff;
      pending_weight_in = pending_weight_ff;
      r                 = '0;
      lon_code          = lhc_pkg::token_code(token_first_ff, stage_char);
      rec               = {lat_code_ff, 2'b00} - {2'b00, lat_code_ff} + {2'b00, lon_code};

      if (stage_char == lhc_pkg::CH_SEMI) begin
         if (pending_valid_ff) begin
            r.ch0 = lhc_pkg::pair_char(pending_weight_ff, 4'd4);
            r.ch1 = lhc_pkg::CH_SPACE;
            r.cnt = 2'd2;
         end else begin
            r.ch0 = lhc_pkg::CH_SPACE;
            r.cnt = 2'd1;
         end
         pending_valid_in  = 1'b0;
         pending_weight_in = '0;
         in_location_in    = 1'b1;
         char_position_in  = '0;
         lat_code_in       = lhc_pkg::CODE_ZERO;
      end else if (in_location_ff) begin
         r.ch0 = stage_char;
         r.cnt = 2'd1;
         if (char_position_ff >= lhc_pkg::LOCATION_LAST) begin
            in_location_in   = 1'b0;
            char_position_in = '0;
         end else begin
            char_position_in = char_position_ff + 3'd1;
         end
      end else begin
         unique case (char_position_ff[1:0])
            2'd0, 2'd2: token_first_in = stage_char;
            2'd1:       lat_code_in = lon_code;
            2'd3: begin
               if (pending_valid_ff) begin
                  r.ch0             = lhc_pkg::pair_char(pending_weight_ff, rec);
                  r.cnt             = 2'd1;
                  pending_valid_in  = 1'b0;
                  pending_weight_in = '0;
               end else begin
                  pending_valid_in  = 1'b1;
                  pending_weight_in = rec;
               end
            end
            default: token_first_in = token_first_ff;
         endcase
         char_position_in = {1'b0, char_position_ff[1:0] + 2'd1};
      end

      if (stage_end) begin
         if (pending_valid_in) begin
            if (r.cnt == 2'd0) begin
               r.ch0 = lhc_pkg::pair_char(pending_weight_in, 4'd4);
            end else begin
               r.ch1 = lhc_pkg::pair_char(pending_weight_in, 4'd4);
            end
            r.cnt = r.cnt + 2'd1;
         end
         in_location_in    = 1'b1;
         char_position_in  = '0;
         token_first_in    = '0;
         lat_code_in       = lhc_pkg::CODE_ZERO;
         pending_valid_in  = 1'b0;
         pending_weight_in = '0;
      end

      res = r;
      if (!stage_valid) begin
         res.cnt = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_location_ff    <= 1'b1;
         char_position_ff  <= '0;
         token_first_ff    <= '0;
         lat_code_ff       <= lhc_pkg::CODE_ZERO;
         pending_valid_ff  <= 1'b0;
         pending_weight_ff <= '0;
      end else if (stage_valid && stage_advance) begin
         in_location_ff    <= in_location_in;
         char_position_ff  <= char_position_in;
         token_first_ff    <= token_first_in;
         lat_code_ff       <= lat_code_in;
         pending_valid_ff  <= pending_valid_in;
         pending_weight_ff <= pending_weight_in;
      end
   end

endmodule

>>> sv/lhc_out_queue.sv
// Result queue: takes up to two characters a cycle, delivers one beat a cycle while rsp_stall is low.
module lhc_out_queue #(
   parameter int DEPTH = lhc_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  lhc_pkg::lhc_res_type push,
   input  logic                push_en,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_message_char,
   output logic                rsp_run_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   lhc_pkg::lhc_entry_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pop;
   logic [1:0]    n_push;
   logic [AW-1:0] wr_next;

   assign n_push  = push_en ? push.cnt : 2'd0;
   assign pop     = rsp_valid && !rsp_stall;
   assign room    = (CW'(DEPTH) - count_ff) >= CW'(2);
   assign wr_next = wr_ff + AW'(1);

   assign rsp_valid        = count_ff != '0;
   assign rsp_message_char = mem_ff[rd_ff].ch;
   assign rsp_run_last     = mem_ff[rd_ff].last;

   always_comb begin
      wr_in    = wr_ff + AW'(n_push);
      rd_in    = pop ? rd_ff + AW'(1) : rd_ff;
      count_in = count_ff + CW'(n_push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem_ff[wr_ff] <= '{last: (n_push == 2'd1), ch: push.ch0};
      end
      if (n_push == 2'd2) begin
         mem_ff[wr_next] <= '{last: 1'b1, ch: push.ch1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> sv/location_history_compactor.sv
// Top level of the location history compactor.
// A character's first result passes through the input stage register and the result queue to rsp_valid.
// Throughput: one character per cycle while the queue has room; a character with two
// results gives two beats on the result side, and the 4-entry result queue absorbs that.
// The input stage waits whenever the queue has fewer than two free entries.
// Synchronous reset empties the queue and returns the parser to the start of a text.
module location_history_compactor #(
   parameter int QUEUE_DEPTH = lhc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_char,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_message_char,
   output logic       rsp_run_last
);

   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_char_ff;
   logic       stage_end_ff;
   logic       stage_advance;
   logic       room;
   lhc_pkg::lhc_res_type res;

   assign stage_advance  = room;
   assign req_stall      = stage_valid_ff && !stage_advance;
   assign stage_valid_in = req_stall ? stage_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         stage_char_ff <= req_text_char;
         stage_end_ff  <= req_end_of_text;
      end
   end

   lhc_step u_step (
      .clock         (clock),
      .reset         (reset),
      .stage_valid   (stage_valid_ff),
      .stage_advance (stage_advance),
      .stage_char    (stage_char_ff),
      .stage_end     (stage_end_ff),
      .res           (res)
   );

   lhc_out_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock            (clock),
      .reset            (reset),
      .push             (res),
      .push_en          (stage_advance),
      .room             (room),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_message_char (rsp_message_char),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

>>> sv/lhc_checker.sv
// Port-level checker for the location history compactor, bound to the top level.
module lhc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_text_char,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_message_char,
   input logic       rsp_run_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("outputs not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_message_char) && $stable(rsp_run_last))
      else $error("stalled rsp beat changed");

   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_message_char, rsp_run_last}))
      else $error("rsp beat carries unknown bits");

   a_semi_space: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_text_char == lhc_pkg::CH_SEMI |=> ##1 rsp_valid)
      else $error("semicolon produced no result");

endmodule

bind location_history_compactor lhc_checker u_lhc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_text_char    (req_text_char),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_message_char (rsp_message_char),
   .rsp_run_last     (rsp_run_last)
);
